FILE: sv/eci_pkg.sv
`timescale 1ns / 1ps

package eci_pkg;

  // fixed formats
  localparam int FRAC_BITS = 16;
  localparam int VAL_BITS  = 16;
  localparam int SEG_BITS  = 8;
  localparam int SEGMENTS  = 1 << SEG_BITS;
  localparam int ONE       = 1 << FRAC_BITS;

  // back curve coefficients, rounded to the fraction grid
  localparam longint KB3 = (longint'(270158) * ONE + 50000) / 100000;
  localparam longint KB1 = (longint'(170158) * ONE + 50000) / 100000;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [63:0] LN2_Q60 = 64'h0B17217F7D1CF79B;
  localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

  typedef enum logic [3:0] {
    CRV_QUAD     = 4'd0,
    CRV_CUBIC    = 4'd1,
    CRV_QUART    = 4'd2,
    CRV_QUINT    = 4'd3,
    CRV_SINE     = 4'd4,
    CRV_EXP      = 4'd5,
    CRV_CIRC     = 4'd6,
    CRV_BACK     = 4'd7,
    CRV_SOFTBACK = 4'd8,
    CRV_ELASTIC  = 4'd9,
    CRV_LINEAR   = 4'd11
  } curve_e;

  typedef enum logic [1:0] {
    MODE_IN    = 2'd0,
    MODE_OUT   = 2'd1,
    MODE_INOUT = 2'd2
  } mode_e;

  typedef logic [FRAC_BITS:0] rom_word_t;
  typedef rom_word_t rom_t [0:SEGMENTS];

  // product of two Q60 numbers, kept to 64 bits
  function automatic logic [63:0] mul60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // 1 - cos(x*pi/2) by a Taylor series in Q60
  function automatic rom_t build_sine();
    rom_t        tab;
    logic [63:0] ystep;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] sum;
    ystep = (PI_Q60 / 2) / SEGMENTS;
    for (int i = 0; i <= SEGMENTS; i++) begin
      y    = ystep * 64'(i);
      y2   = mul60(y, y);
      term = y2 >> 1;
      sum  = term;
      for (int k = 2; k <= 20; k++) begin
        term = mul60(term, y2) / 64'((2 * k - 1) * (2 * k));
        if ((k & 1) == 1) begin
          sum = sum + term;
        end else begin
          sum = sum - term;
        end
      end
      tab[i] = rom_word_t'((sum + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
    end
    return tab;
  endfunction

  // 2^(10x - 10), zero at the origin
  function automatic rom_t build_exp();
    rom_t        tab;
    logic [63:0] zstep;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    int          e;
    int          q;
    int          sh;
    zstep = LN2_Q60 / SEGMENTS;
    for (int i = 0; i <= SEGMENTS; i++) begin
      e    = 10 * i;
      q    = e / SEGMENTS;
      z    = zstep * 64'(e % SEGMENTS);
      term = ONE_Q60;
      sum  = ONE_Q60;
      for (int k = 1; k <= 30; k++) begin
        term = mul60(term, z) / 64'(k);
        sum  = sum + term;
      end
      sh = 70 - FRAC_BITS - q;
      if (i == 0) begin
        tab[i] = '0;
      end else begin
        tab[i] = rom_word_t'((sum + (64'd1 << (sh - 1))) >> sh);
      end
    end
    return tab;
  endfunction

  // 1 - sqrt(1 - x^2) by exact search on the rounding bound
  function automatic rom_t build_circ();
    rom_t         tab;
    logic [63:0]  m;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    logic [63:0]  u;
    logic [127:0] lhs;
    logic [127:0] rhs;
    for (int i = 0; i <= SEGMENTS; i++) begin
      m  = 64'(SEGMENTS * SEGMENTS - i * i);
      lo = '0;
      hi = 64'(ONE);
      for (int it = 0; it < 32; it++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          u   = (64'd2 * mid - 64'd1) * 64'(SEGMENTS);
          lhs = {64'd0, u} * {64'd0, u};
          rhs = {64'd0, 64'(2 * ONE)} * {64'd0, 64'(2 * ONE) * m};
          if (lhs <= rhs) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      tab[i] = rom_word_t'(64'(ONE) - lo);
    end
    return tab;
  endfunction

  localparam rom_t SINE_ROM = build_sine();
  localparam rom_t EXP_ROM  = build_exp();
  localparam rom_t CIRC_ROM = build_circ();

endpackage

FILE: sv/easing_curve_interpolator_core.sv
// throughput: one word per clock, start is taken in every cycle (busy_o stays low)
// the pipeline has nine register stages: power chain, curve select, mode, multiply, clamp
// results are strobed by done_o for one cycle, the receiver cannot stall
// reset is asynchronous, active low, and clears the valid bits; the datapath stages are not reset
`timescale 1ns / 1ps

module easing_curve_interpolator_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [eci_pkg::FRAC_BITS:0]          progress_i,
  input  logic [3:0]                           curve_select_i,
  input  logic [1:0]                           ease_mode_i,
  input  logic signed [eci_pkg::VAL_BITS-1:0]  start_value_i,
  input  logic signed [eci_pkg::VAL_BITS-1:0]  end_value_i,
  output logic                                 done_o,
  output logic signed [eci_pkg::VAL_BITS-1:0]  eased_value_o,
  output logic                                 select_error_o
);
  import eci_pkg::*;

  localparam int NST = 9;
  localparam int UW  = FRAC_BITS + 1;

  typedef struct packed {
    logic                       err;
    logic [3:0]                 curve;
    logic [1:0]                 mode;
    logic                       upper;
    logic signed [VAL_BITS-1:0] a;
    logic signed [VAL_BITS:0]   d;
  } ctl_t;

  logic [NST:1] vld_q;
  ctl_t         ctl_q [1:NST];
  ctl_t         ctl_d;

  logic [UW-1:0] t_sat;
  logic [UW:0]   t_dbl;
  logic [UW-1:0] u_d;

  logic [UW-1:0] s1_u_q;
  logic [UW-1:0] s2_u_q, s2_t2_q, s2_tlo_q, s2_thi_q;
  logic [FRAC_BITS-1:0] s2_r_q;
  logic [SEG_BITS:0] rom_k, rom_kn;
  logic [UW-1:0] tlo_d, thi_d;

  logic [UW-1:0] s3_u_q, s3_t2_q, s3_t3_q, s3_rom_q;
  logic [UW:0]   s3_kbt_q;
  logic signed [UW:0]       rom_diff;
  logic signed [2*UW:0]     rom_prod;
  logic signed [UW+1:0]     rom_d;

  logic [UW-1:0] s4_u_q, s4_t2_q, s4_t3_q, s4_t4_q, s4_rom_q;
  logic signed [UW+1:0] s4_back_q, s4_soft_q;
  logic signed [UW+1:0] back_x, soft_x;
  logic signed [2*UW+2:0] back_p, soft_p;

  logic [UW-1:0] s5_u_q, s5_t2_q, s5_t3_q, s5_t4_q, s5_t5_q, s5_rom_q;
  logic signed [UW+1:0] s5_back_q, s5_soft_q;

  logic signed [25:0] f_d, f_q;
  logic signed [25:0] elastic;
  logic signed [26:0] s_d, s_q;
  logic signed [26:0] f_half;
  logic signed [43:0] res_p;
  logic signed [27:0] prod_d, prod_q;
  logic signed [28:0] v_sum;
  logic signed [VAL_BITS-1:0] out_d, out_q;

  localparam logic signed [26:0] ONE_S = 27'(ONE);
  localparam logic signed [28:0] VMAX  = 29'((1 << (VAL_BITS - 1)) - 1);
  localparam logic signed [28:0] VMIN  = -VMAX - 29'sd1;

  // the pipeline never stalls
  assign busy_o = 1'b0;

  // progress clamp and mode folding onto the curve argument
  always_comb begin
    t_sat = (progress_i > UW'(ONE)) ? UW'(ONE) : progress_i;
    t_dbl = {t_sat, 1'b0};
    ctl_d.err   = !(curve_select_i <= 4'(CRV_ELASTIC) || curve_select_i == 4'(CRV_LINEAR))
                  || !(ease_mode_i == 2'(MODE_IN) || ease_mode_i == 2'(MODE_OUT)
                       || ease_mode_i == 2'(MODE_INOUT));
    ctl_d.curve = curve_select_i;
    ctl_d.mode  = ease_mode_i;
    ctl_d.upper = (t_dbl >= (UW + 1)'(ONE));
    ctl_d.a     = start_value_i;
    ctl_d.d     = (VAL_BITS + 1)'(end_value_i) - (VAL_BITS + 1)'(start_value_i);
    case (mode_e'(ease_mode_i))
      MODE_OUT:   u_d = UW'(ONE) - t_sat;
      MODE_INOUT: u_d = ctl_d.upper ? UW'((UW + 1)'(2 * ONE) - t_dbl) : UW'(t_dbl);
      default:    u_d = t_sat;
    endcase
  end

  // table address and picked table
  always_comb begin
    rom_k  = (SEG_BITS + 1)'(s1_u_q >> (FRAC_BITS - SEG_BITS));
    rom_kn = (rom_k == (SEG_BITS + 1)'(SEGMENTS)) ? rom_k : rom_k + 1'b1;
    case (curve_e'(ctl_q[1].curve))
      CRV_SINE: begin
        tlo_d = SINE_ROM[rom_k];
        thi_d = SINE_ROM[rom_kn];
      end
      CRV_EXP: begin
        tlo_d = EXP_ROM[rom_k];
        thi_d = EXP_ROM[rom_kn];
      end
      CRV_CIRC: begin
        tlo_d = CIRC_ROM[rom_k];
        thi_d = CIRC_ROM[rom_kn];
      end
      default: begin
        tlo_d = '0;
        thi_d = '0;
      end
    endcase
  end

  // linear interpolation between table entries, floor on the fraction
  always_comb begin
    rom_diff = $signed({1'b0, s2_thi_q}) - $signed({1'b0, s2_tlo_q});
    rom_prod = (2 * UW + 1)'(rom_diff) * $signed({2'b0, s2_r_q});
    rom_d    = $signed({2'b0, s2_tlo_q}) + (UW + 2)'(rom_prod >>> FRAC_BITS);
  end

  // back and soft back inner factors times t squared
  always_comb begin
    back_x = $signed({1'b0, s3_kbt_q}) - (UW + 2)'(KB1);
    soft_x = $signed({1'b0, s3_u_q, 1'b0}) - (UW + 2)'(ONE);
    back_p = (2 * UW + 3)'($signed({1'b0, s3_t2_q})) * (2 * UW + 3)'(back_x);
    soft_p = (2 * UW + 3)'($signed({1'b0, s3_t2_q})) * (2 * UW + 3)'(soft_x);
  end

  // curve select
  always_comb begin
    elastic = 26'sd56 * $signed({9'd0, s5_t5_q}) - 26'sd105 * $signed({9'd0, s5_t4_q})
              + 26'sd60 * $signed({9'd0, s5_t3_q}) - 26'sd10 * $signed({9'd0, s5_t2_q});
    case (curve_e'(ctl_q[5].curve))
      CRV_QUAD:     f_d = $signed({9'd0, s5_t2_q});
      CRV_CUBIC:    f_d = $signed({9'd0, s5_t3_q});
      CRV_QUART:    f_d = $signed({9'd0, s5_t4_q});
      CRV_QUINT:    f_d = $signed({9'd0, s5_t5_q});
      CRV_SINE,
      CRV_EXP,
      CRV_CIRC:     f_d = $signed({9'd0, s5_rom_q});
      CRV_BACK:     f_d = 26'(s5_back_q);
      CRV_SOFTBACK: f_d = 26'(s5_soft_q);
      CRV_ELASTIC:  f_d = elastic;
      default:      f_d = $signed({9'd0, s5_u_q});
    endcase
  end

  // mode shaping of the curve value
  always_comb begin
    f_half = 27'(f_q) >>> 1;
    case (mode_e'(ctl_q[6].mode))
      MODE_OUT:   s_d = ONE_S - 27'(f_q);
      MODE_INOUT: s_d = ctl_q[6].upper ? ONE_S - f_half : f_half;
      default:    s_d = 27'(f_q);
    endcase
  end

  // span times shaped progress, rounded
  always_comb begin
    res_p  = 44'(ctl_q[7].d) * 44'(s_q);
    prod_d = 28'((res_p + 44'(ONE / 2)) >>> FRAC_BITS);
  end

  // offset, saturate, error forcing
  always_comb begin
    v_sum = 29'(ctl_q[8].a) + 29'(prod_q);
    if (ctl_q[8].err) begin
      out_d = '0;
    end else if (v_sum > VMAX) begin
      out_d = VAL_BITS'(VMAX);
    end else if (v_sum < VMIN) begin
      out_d = VAL_BITS'(VMIN);
    end else begin
      out_d = VAL_BITS'(v_sum);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NST-1:1], start_i & ~busy_o};
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    ctl_q[1] <= ctl_d;
    for (int n = 2; n <= NST; n++) begin
      ctl_q[n] <= ctl_q[n-1];
    end
    s1_u_q <= u_d;

    s2_u_q   <= s1_u_q;
    s2_t2_q  <= UW'(((2 * UW)'(s1_u_q) * (2 * UW)'(s1_u_q)) >> FRAC_BITS);
    s2_tlo_q <= tlo_d;
    s2_thi_q <= thi_d;
    s2_r_q   <= FRAC_BITS'(s1_u_q << SEG_BITS);

    s3_u_q   <= s2_u_q;
    s3_t2_q  <= s2_t2_q;
    s3_t3_q  <= UW'(((2 * UW)'(s2_t2_q) * (2 * UW)'(s2_u_q)) >> FRAC_BITS);
    s3_kbt_q <= (UW + 1)'(((2 * UW + 1)'(KB3) * (2 * UW + 1)'(s2_u_q)) >> FRAC_BITS);
    s3_rom_q <= UW'(rom_d);

    s4_u_q    <= s3_u_q;
    s4_t2_q   <= s3_t2_q;
    s4_t3_q   <= s3_t3_q;
    s4_t4_q   <= UW'(((2 * UW)'(s3_t3_q) * (2 * UW)'(s3_u_q)) >> FRAC_BITS);
    s4_rom_q  <= s3_rom_q;
    s4_back_q <= (UW + 2)'(back_p >>> FRAC_BITS);
    s4_soft_q <= (UW + 2)'(soft_p >>> FRAC_BITS);

    s5_u_q    <= s4_u_q;
    s5_t2_q   <= s4_t2_q;
    s5_t3_q   <= s4_t3_q;
    s5_t4_q   <= s4_t4_q;
    s5_t5_q   <= UW'(((2 * UW)'(s4_t4_q) * (2 * UW)'(s4_u_q)) >> FRAC_BITS);
    s5_rom_q  <= s4_rom_q;
    s5_back_q <= s4_back_q;
    s5_soft_q <= s4_soft_q;

    f_q    <= f_d;
    s_q    <= s_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign done_o         = vld_q[NST];
  assign eased_value_o  = out_q;
  assign select_error_o = ctl_q[NST].err;

`ifndef NO_ASSERTIONS
  // every accepted word comes out with a done_o strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##9 done_o)
    else $error("accepted word did not complete");

  // no result without an accepted word
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 9))
    else $error("result without accepted word");

  // unsupported selections give a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && select_error_o |-> eased_value_o == '0)
    else $error("error result carries a value");
`endif

endmodule
